// ----- src/tcp_byte_stream_reassembler_assert.svh -----
// Assertion macros shared by the reassembler RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef TCP_BYTE_STREAM_REASSEMBLER_ASSERT_SVH
`define TCP_BYTE_STREAM_REASSEMBLER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TBSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TBSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tbsr_pkg.sv -----
// Shared types and constants for the TCP byte stream reassembler.
// Depends on nothing; used by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tbsr_pkg;

  localparam int DEF_BUFFER_DEPTH = 64;   // ring slots
  localparam int MAX_RESULTS      = 64;   // bytes released per transaction at most
  localparam int IDX_W            = 64;   // stream index width
  localparam int BYTE_W           = 8;
  localparam int CNT_W            = 7;    // window, counts and offsets
  localparam int MAX_WINDOW       = 2**CNT_W - 1;
  localparam int CHUNK_W          = 16;   // valid bits counted per tree leaf
  localparam int QUEUE_DEPTH      = 2;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // One classified transaction waiting for the engine
  typedef struct packed {
    logic              is_end;
    logic [IDX_W-1:0]  pos;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  win;   // usable window, min(space, depth)
    logic [CNT_W-1:0]  lim;   // release limit, min(win, MAX_RESULTS)
  } item_t;

  typedef enum logic [3:0] {
    ENG_IDLE,
    ENG_CHECK,
    ENG_APPLY,
    ENG_TREE,
    ENG_SUM,
    ENG_CLOSE,
    ENG_READ,
    ENG_SEND,
    ENG_NONE
  } eng_state_t;

endpackage

`default_nettype wire

// ----- src/tbsr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on tbsr_pkg for default sizes only.
`timescale 1ns / 1ps
`default_nettype none

module tbsr_ram #(
  parameter int WIDTH = tbsr_pkg::BYTE_W,
  parameter int DEPTH = tbsr_pkg::DEF_BUFFER_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/tbsr_front.sv -----
// Input side: takes transactions, clamps the window and queues them.
// Depends on tbsr_pkg for the item type and size constants.
`timescale 1ns / 1ps
`default_nettype none

module tbsr_front #(
  parameter int BUFFER_DEPTH = tbsr_pkg::DEF_BUFFER_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [tbsr_pkg::IDX_W-1:0]   in_stream_index,
  input  wire logic [tbsr_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic [tbsr_pkg::CNT_W-1:0]   in_window_space,
  output logic                              q_valid,
  output tbsr_pkg::item_t                   q_item,
  input  wire logic                         q_pop
);

  localparam int QP_W = $clog2(tbsr_pkg::QUEUE_DEPTH);
  localparam int QC_W = $clog2(tbsr_pkg::QUEUE_DEPTH + 1);

  tbsr_pkg::item_t  entry_r [tbsr_pkg::QUEUE_DEPTH];
  tbsr_pkg::item_t  cls_item;
  logic [QP_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  cnt_r, cnt_nxt;
  logic             push;
  logic [tbsr_pkg::CNT_W-1:0] win;

  // Classify: decode kind, clamp window to ring size and release limit
  always_comb begin
    if (32'(in_window_space) > BUFFER_DEPTH) begin
      win = tbsr_pkg::CNT_W'(BUFFER_DEPTH);
    end else begin
      win = in_window_space;
    end
    cls_item.is_end = (in_kind == tbsr_pkg::KIND_END);
    cls_item.pos    = in_stream_index;
    cls_item.data   = in_data_byte;
    cls_item.win    = win;
    if (win > tbsr_pkg::CNT_W'(tbsr_pkg::MAX_RESULTS)) begin
      cls_item.lim = tbsr_pkg::CNT_W'(tbsr_pkg::MAX_RESULTS);
    end else begin
      cls_item.lim = win;
    end
  end

  // Queue bookkeeping
  assign in_stall = (cnt_r == QC_W'(tbsr_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(tbsr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(tbsr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QC_W'(push) - QC_W'(q_pop);
  end

  // Hold pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified transaction
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

// ----- src/tbsr_engine.sv -----
// Back side: applies one queued transaction to the ring and releases the run.
// Depends on tbsr_pkg and instantiates tbsr_ram for the byte store.
`timescale 1ns / 1ps
`default_nettype none

module tbsr_engine #(
  parameter int BUFFER_DEPTH = tbsr_pkg::DEF_BUFFER_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire tbsr_pkg::item_t              q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_has_byte,
  output logic [tbsr_pkg::BYTE_W-1:0]       out_out_byte,
  output logic                              out_run_last,
  output logic [tbsr_pkg::CNT_W-1:0]        out_pending_count,
  output logic                              out_stream_closed
);

  localparam int AW     = $clog2(BUFFER_DEPTH);
  localparam int VLEN   = (BUFFER_DEPTH < tbsr_pkg::MAX_WINDOW) ?
                          BUFFER_DEPTH : tbsr_pkg::MAX_WINDOW;
  localparam int VIDX_W = $clog2(VLEN);
  localparam int NCH    = (VLEN + tbsr_pkg::CHUNK_W - 1) / tbsr_pkg::CHUNK_W;
  localparam int VPAD   = NCH * tbsr_pkg::CHUNK_W;
  localparam int CC_W   = $clog2(tbsr_pkg::CHUNK_W + 1);
  localparam int SW     = ((AW > tbsr_pkg::CNT_W) ? AW : tbsr_pkg::CNT_W) + 1;
  localparam int IW     = tbsr_pkg::IDX_W;
  localparam int CW     = tbsr_pkg::CNT_W;

  tbsr_pkg::eng_state_t state_r, state_nxt;

  // Valid marks held by offset from next_index: bit k is stream position next + k
  logic [VLEN-1:0]        valid_r, valid_nxt;
  logic [IW-1:0]          next_r, next_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic                   end_known_r, end_known_nxt;
  logic [IW-1:0]          end_r, end_nxt;
  tbsr_pkg::item_t        cur_r, cur_nxt;
  logic                   in_win_r, in_win_nxt;
  logic [CW-1:0]          off_r, off_nxt;
  logic [CC_W-1:0]        ccnt_r [NCH];
  logic [CC_W-1:0]        clead_r [NCH];
  logic [CC_W-1:0]        ccnt_nxt [NCH];
  logic [CC_W-1:0]        clead_nxt [NCH];
  logic [CW-1:0]          pend_r, pend_nxt;
  logic [CW-1:0]          remain_r, remain_nxt;
  logic                   closed_r, closed_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_has_byte_r, out_has_byte_nxt;
  logic [tbsr_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [CW-1:0]          out_pend_r, out_pend_nxt;
  logic                   out_closed_r, out_closed_nxt;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr;
  logic [tbsr_pkg::BYTE_W-1:0] ram_rdata;

  logic [IW-1:0]          off64;
  logic                   in_win_calc;
  logic [VLEN-1:0]        wmask;
  logic [SW-1:0]          slot_sum;
  logic [AW-1:0]          wslot;
  logic [CW-1:0]          total_calc, run_calc, run_cap;
  logic [IW-1:0]          next_final;
  logic                   out_free;

  // Window test for the current data byte
  always_comb begin
    off64       = cur_r.pos - next_r;
    in_win_calc = (cur_r.pos >= next_r) && (off64 < IW'(cur_r.win));
  end

  // Shrink mask and ring slot of the written byte
  always_comb begin
    for (int k = 0; k < VLEN; k++) begin
      wmask[k] = (CW'(k) < cur_r.win);
    end
    slot_sum = SW'(head_r) + SW'(off_r);
    if (slot_sum >= SW'(BUFFER_DEPTH)) begin
      slot_sum = slot_sum - SW'(BUFFER_DEPTH);
    end
    wslot = AW'(slot_sum);
  end

  // First tree level: count and leading run per chunk of valid marks
  always_comb begin
    logic [VPAD-1:0] vpad;
    logic            go;
    vpad = VPAD'(valid_r);
    for (int c = 0; c < NCH; c++) begin
      ccnt_nxt[c]  = '0;
      clead_nxt[c] = '0;
      go           = 1'b1;
      for (int b = 0; b < tbsr_pkg::CHUNK_W; b++) begin
        ccnt_nxt[c] = ccnt_nxt[c] + CC_W'(vpad[c*tbsr_pkg::CHUNK_W + b]);
        if (go && vpad[c*tbsr_pkg::CHUNK_W + b]) begin
          clead_nxt[c] = clead_nxt[c] + 1'b1;
        end else begin
          go = 1'b0;
        end
      end
    end
  end

  // Second tree level: total stored and length of the run from the head
  always_comb begin
    logic go;
    total_calc = '0;
    run_calc   = '0;
    go         = 1'b1;
    for (int c = 0; c < NCH; c++) begin
      total_calc = total_calc + CW'(ccnt_r[c]);
      if (go) begin
        run_calc = run_calc + CW'(clead_r[c]);
      end
      if (clead_r[c] != CC_W'(tbsr_pkg::CHUNK_W)) begin
        go = 1'b0;
      end
    end
    run_cap = (run_calc < cur_r.lim) ? run_calc : cur_r.lim;
  end

  assign next_final = next_r + IW'(remain_r);
  assign out_free   = !out_valid_r || !out_stall;

  // Sequencer: next state, datapath updates and output register loads
  always_comb begin
    state_nxt        = state_r;
    valid_nxt        = valid_r;
    next_nxt         = next_r;
    head_nxt         = head_r;
    end_known_nxt    = end_known_r;
    end_nxt          = end_r;
    cur_nxt          = cur_r;
    in_win_nxt       = in_win_r;
    off_nxt          = off_r;
    pend_nxt         = pend_r;
    remain_nxt       = remain_r;
    closed_nxt       = closed_r;
    out_valid_nxt    = out_valid_r;
    out_has_byte_nxt = out_has_byte_r;
    out_byte_nxt     = out_byte_r;
    out_last_nxt     = out_last_r;
    out_pend_nxt     = out_pend_r;
    out_closed_nxt   = out_closed_r;
    q_pop            = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = wslot;

    // Drop a result once it is taken (valid and no stall)
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      tbsr_pkg::ENG_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = tbsr_pkg::ENG_CHECK;
        end
      end
      tbsr_pkg::ENG_CHECK: begin
        in_win_nxt = in_win_calc;
        off_nxt    = off64[CW-1:0];
        state_nxt  = tbsr_pkg::ENG_APPLY;
      end
      tbsr_pkg::ENG_APPLY: begin
        // Drop marks beyond the window, then store the byte or note the end
        valid_nxt = valid_r & wmask;
        if (cur_r.is_end) begin
          end_known_nxt = 1'b1;
          end_nxt       = cur_r.pos;
        end else if (in_win_r) begin
          valid_nxt[off_r[VIDX_W-1:0]] = 1'b1;
          ram_we                       = 1'b1;
        end
        state_nxt = tbsr_pkg::ENG_TREE;
      end
      tbsr_pkg::ENG_TREE: begin
        state_nxt = tbsr_pkg::ENG_SUM;
      end
      tbsr_pkg::ENG_SUM: begin
        remain_nxt = run_cap;
        pend_nxt   = total_calc - run_cap;
        state_nxt  = tbsr_pkg::ENG_CLOSE;
      end
      tbsr_pkg::ENG_CLOSE: begin
        closed_nxt = end_known_r && (next_final >= end_r);
        state_nxt  = (remain_r == '0) ? tbsr_pkg::ENG_NONE : tbsr_pkg::ENG_READ;
      end
      tbsr_pkg::ENG_READ: begin
        ram_re    = 1'b1;
        state_nxt = tbsr_pkg::ENG_SEND;
      end
      tbsr_pkg::ENG_SEND: begin
        // Release the head byte and advance the ring
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_has_byte_nxt = 1'b1;
          out_byte_nxt     = ram_rdata;
          out_last_nxt     = (remain_r == CW'(1));
          out_pend_nxt     = pend_r;
          out_closed_nxt   = closed_r;
          valid_nxt        = valid_r >> 1;
          next_nxt         = next_r + IW'(1);
          head_nxt         = (head_r == AW'(BUFFER_DEPTH - 1)) ? '0 : head_r + 1'b1;
          remain_nxt       = remain_r - CW'(1);
          state_nxt        = (remain_r == CW'(1)) ? tbsr_pkg::ENG_IDLE : tbsr_pkg::ENG_READ;
        end
      end
      tbsr_pkg::ENG_NONE: begin
        // Report status without a byte
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_has_byte_nxt = 1'b0;
          out_byte_nxt     = '0;
          out_last_nxt     = 1'b1;
          out_pend_nxt     = pend_r;
          out_closed_nxt   = closed_r;
          state_nxt        = tbsr_pkg::ENG_IDLE;
        end
      end
      default: begin
        state_nxt = tbsr_pkg::ENG_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbsr_pkg::ENG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      next_r      <= '0;
      head_r      <= '0;
      end_known_r <= 1'b0;
      end_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      next_r      <= next_nxt;
      head_r      <= head_nxt;
      end_known_r <= end_known_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r          <= cur_nxt;
    in_win_r       <= in_win_nxt;
    off_r          <= off_nxt;
    ccnt_r         <= ccnt_nxt;
    clead_r        <= clead_nxt;
    pend_r         <= pend_nxt;
    remain_r       <= remain_nxt;
    closed_r       <= closed_nxt;
    out_has_byte_r <= out_has_byte_nxt;
    out_byte_r     <= out_byte_nxt;
    out_last_r     <= out_last_nxt;
    out_pend_r     <= out_pend_nxt;
    out_closed_r   <= out_closed_nxt;
  end

  // Byte store ring
  tbsr_ram #(
    .WIDTH (tbsr_pkg::BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur_r.data),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_has_byte      = out_has_byte_r;
  assign out_out_byte      = out_byte_r;
  assign out_run_last      = out_last_r;
  assign out_pending_count = out_pend_r;
  assign out_stream_closed = out_closed_r;

endmodule

`default_nettype wire

// ----- src/tcp_byte_stream_reassembler.sv -----
// Reassembles out-of-order stream bytes into an in-order byte stream. Each input
// transaction is a data byte or an end-of-stream marker at a 64-bit stream index,
// plus the writer's free space. A two-entry queue parts the input from the engine.
// The engine takes one transaction at a time: it checks the window, updates the
// ring and counts the releasable run, then reads and sends each released byte in
// turn, holding while the output stalls (the byte store has one registered read
// port and the run is walked one slot at a time), or sends one status-only result.
// Valid marks sit in min(BUFFER_DEPTH, 127) flip-flops cleared at reset, so
// no clearing pass runs after reset.
// Depends on tbsr_pkg, tbsr_front, tbsr_engine and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "tcp_byte_stream_reassembler_assert.svh"

module tcp_byte_stream_reassembler #(
  parameter int BUFFER_DEPTH = tbsr_pkg::DEF_BUFFER_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [tbsr_pkg::IDX_W-1:0]   in_stream_index,
  input  wire logic [tbsr_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic [tbsr_pkg::CNT_W-1:0]   in_window_space,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_has_byte,
  output logic [tbsr_pkg::BYTE_W-1:0]       out_out_byte,
  output logic                              out_run_last,
  output logic [tbsr_pkg::CNT_W-1:0]        out_pending_count,
  output logic                              out_stream_closed
);

  logic            q_valid;
  logic            q_pop;
  tbsr_pkg::item_t q_item;

  // Accept and classify transactions
  tbsr_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_stream_index (in_stream_index),
    .in_data_byte    (in_data_byte),
    .in_window_space (in_window_space),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // Apply to the ring and release the in-order run
  tbsr_engine #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_has_byte      (out_has_byte),
    .out_out_byte      (out_out_byte),
    .out_run_last      (out_run_last),
    .out_pending_count (out_pending_count),
    .out_stream_closed (out_stream_closed)
  );

  // A status-only result always closes its transaction's results
  `TBSR_ASSERT_SAME(a_nobyte_last, clk, rst_n, out_valid && !out_has_byte, out_run_last, "status-only result without run_last")
  // Pending bytes never exceed the ring
  `TBSR_ASSERT_SAME(a_pend_bound, clk, rst_n, out_valid, 32'(out_pending_count) <= BUFFER_DEPTH, "pending count beyond ring size")
  // A run is never cut by a status-only result
  `TBSR_ASSERT_NEXT(a_run_cont, clk, rst_n, out_valid && !out_stall && out_has_byte && !out_run_last, !out_valid || out_has_byte, "run interrupted by a status-only result")

endmodule

`default_nettype wire
